@@ rtl/gbp_pkg.sv @@
// Goertzel bin power bank package: payload types, fixed widths and the elaboration-time
// coefficient function. Depends on nothing; every rtl file but gbp_bar_div uses it.

package gbp_pkg;

  localparam int StateW       = 48;
  localparam int StateFrac    = 14;
  localparam int IntW         = StateW - StateFrac;
  localparam int NumBins      = 64;
  localparam int CoefFracBits = 14;
  localparam logic [7:0] BarColsReset = 8'd40;

  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned TwoPiQ30  = 64'd6746518852;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Divisors (2i-1)*(2i) of the cosine series terms.
  localparam longint unsigned TaylorDiv [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  typedef struct packed {
    logic signed [7:0] sample;
    logic              last_sample;
  } in_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [63:0] bin_power;
    logic [7:0]  bar_length;
    logic        last_bin;
  } out_t;

  // 2*cos of a folded Q30 angle, rounded half away from zero to frac fraction bits.
  function automatic longint coef_of(longint unsigned x_in, int frac);
    longint unsigned x;
    longint unsigned y2;
    longint unsigned term;
    longint unsigned m;
    longint          sum;
    longint          c;
    bit              neg;
    int              sh;
    x   = x_in;
    neg = 1'b0;
    if (x > HalfPiQ30) begin
      x   = PiQ30 - x;
      neg = 1'b1;
    end
    y2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int i = 0; i < 10; i++) begin
      term = ((term * y2) >> 30) / TaylorDiv[i];
      if (i[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    c  = neg ? -sum : sum;
    sh = 29 - frac;
    m  = (c < 0) ? longint'(-c) : longint'(c);
    m  = (m + (64'd1 << (sh - 1))) >> sh;
    return (c < 0) ? -longint'(m) : longint'(m);
  endfunction

endpackage

@@ rtl/goertzel_bin_power_bank.sv @@
// Top level of the Goertzel bin power bank: resonator chain, power pipeline,
// power store, bar divider and the frame sequencer. Depends on gbp_pkg and all rtl modules.

// The block takes one sample per cycle during a frame; every bin's resonator cell
// updates in that same cycle. After the sample flagged last_sample the input stalls
// while the cell chain shifts its states, one bin per cycle, into the power pipeline;
// the chain fills with zeros as it shifts, which clears the resonators. Results then
// leave in bin order, one at a time, each after the eight-step bar divider has run,
// and input is taken again after the last bin has been placed in the output register.

module goertzel_bin_power_bank #(
  parameter int BIN_COUNT      = gbp_pkg::NumBins,
  parameter int COEF_FRAC_BITS = gbp_pkg::CoefFracBits
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gbp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  localparam int SW    = gbp_pkg::StateW;
  localparam int CoefW = COEF_FRAC_BITS + 3;
  localparam int IdxW  = $clog2(BIN_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BIN_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]      state_r, state_nxt;
  logic [IdxW-1:0] cnt_r;
  logic [IdxW-1:0] wr_cnt_r;
  logic [IdxW-1:0] bin_r;
  logic [63:0]     max_r;
  logic [7:0]      bar_cols_r;
  logic [63:0]     pw_hold_r;
  logic [63:0]     rd_data_r;
  logic [63:0]     pmem [BIN_COUNT];
  logic            out_valid_r;
  gbp_pkg::out_t   out_data_r;

  logic in_acc;
  logic upd, shift;
  logic pv;
  logic [63:0] pw;
  logic div_start, div_done;
  logic [7:0] div_q;
  logic out_load;

  logic signed [SW-1:0]    s1_w   [BIN_COUNT];
  logic signed [SW-1:0]    s2_w   [BIN_COUNT];
  logic signed [CoefW-1:0] coef_w [BIN_COUNT];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign upd      = in_acc;
  assign shift    = (state_r == S_DRAIN);

  for (genvar k = 0; k < BIN_COUNT; k++) begin : g_bin
    localparam longint unsigned AFold = (2 * k > BIN_COUNT) ? BIN_COUNT - k : k;
    localparam longint unsigned XQ    = (gbp_pkg::TwoPiQ30 * AFold) / BIN_COUNT;
    localparam logic signed [CoefW-1:0] CoefK =
      CoefW'(gbp_pkg::coef_of(XQ, COEF_FRAC_BITS));
    logic signed [SW-1:0] nb_s1, nb_s2;

    assign coef_w[k] = CoefK;

    if (k == BIN_COUNT - 1) begin : g_tail
      assign nb_s1 = '0;
      assign nb_s2 = '0;
    end else begin : g_mid
      assign nb_s1 = s1_w[k+1];
      assign nb_s2 = s2_w[k+1];
    end

    gbp_cell #(
      .CoefFracBits (COEF_FRAC_BITS),
      .CoefW        (CoefW),
      .Coef         (CoefK)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (upd),
      .shift  (shift),
      .sample (in_data.sample),
      .nb_s1  (nb_s1),
      .nb_s2  (nb_s2),
      .s1     (s1_w[k]),
      .s2     (s2_w[k])
    );
  end

  gbp_power #(
    .CoefFracBits (COEF_FRAC_BITS),
    .CoefW        (CoefW)
  ) u_power (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (shift),
    .s1      (s1_w[0]),
    .s2      (s2_w[0]),
    .coef    (coef_w[cnt_r]),
    .pwr_vld (pv),
    .pwr     (pw)
  );

  assign div_start = (state_r == S_LOAD);

  gbp_bar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .power (rd_data_r),
    .cols  (bar_cols_r),
    .max   (max_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Power store: written by the pipeline, read one bin at a time for the bars.
  always_ff @(posedge clk) begin
    if (pv) begin
      pmem[wr_cnt_r] <= pw;
    end
    rd_data_r <= pmem[bin_r];
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_data.last_sample) state_nxt = S_DRAIN;
      S_DRAIN: if (cnt_r == LastIdx) state_nxt = S_FLUSH;
      S_FLUSH: if (pv && wr_cnt_r == LastIdx) state_nxt = S_RD;
      S_RD:    state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = (bin_r == LastIdx) ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wr_cnt_r    <= '0;
      bin_r       <= '0;
      max_r       <= 64'd1;
      bar_cols_r  <= gbp_pkg::BarColsReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        bar_cols_r <= cfg_wdata;
      end
      if (state_r == S_IDLE) begin
        cnt_r    <= '0;
        wr_cnt_r <= '0;
        bin_r    <= '0;
        max_r    <= 64'd1;
      end
      if (shift) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (pv) begin
        wr_cnt_r <= wr_cnt_r + 1'b1;
        if (pw > max_r) begin
          max_r <= pw;
        end
      end
      if (out_load) begin
        bin_r <= bin_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      pw_hold_r <= rd_data_r;
    end
    if (out_load) begin
      out_data_r.bin_index  <= 6'(bin_r);
      out_data_r.bin_power  <= pw_hold_r;
      out_data_r.bar_length <= div_q;
      out_data_r.last_bin   <= (bin_r == LastIdx);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pwr_in_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    pv |-> (state_r == S_DRAIN || state_r == S_FLUSH))
    else $error("power pipeline produced a value outside the frame-end drain");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("bar divider finished while the sequencer was not waiting for it");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_sample) |=> (state_r == S_DRAIN && cnt_r == '0))
    else $error("last sample did not start the chain drain at bin zero");

endmodule

@@ rtl/gbp_cell.sv @@
// One Goertzel resonator cell holding the two delayed states of its bin.
// Depends on gbp_pkg; instantiated in a chain by goertzel_bin_power_bank.

module gbp_cell #(
  parameter int CoefFracBits = gbp_pkg::CoefFracBits,
  parameter int CoefW        = gbp_pkg::CoefFracBits + 3,
  parameter logic signed [CoefW-1:0] Coef = '0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd,
  input  logic                              shift,
  input  logic signed [7:0]                 sample,
  input  logic signed [gbp_pkg::StateW-1:0] nb_s1,
  input  logic signed [gbp_pkg::StateW-1:0] nb_s2,
  output logic signed [gbp_pkg::StateW-1:0] s1,
  output logic signed [gbp_pkg::StateW-1:0] s2
);

  localparam int SW = gbp_pkg::StateW;
  localparam int MW = CoefW - 1;
  localparam int XW = SW + MW;
  localparam int PW = XW - CoefFracBits + 1;
  localparam int VW = PW + 1;
  localparam bit CoefNeg = Coef[CoefW-1];
  localparam logic [MW-1:0] MagC = CoefNeg ? MW'(-Coef) : MW'(Coef);
  localparam logic signed [SW-1:0] StMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] StMin = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] s1_r, s2_r;
  logic [SW-1:0]        ms;
  logic [XW-1:0]        prod;
  logic [XW-1:0]        rnd;
  logic [PW-2:0]        pmag;
  logic signed [PW-1:0] p;
  logic signed [VW-1:0] v;
  logic signed [SW-1:0] s0;

  always_comb begin
    ms   = s1_r[SW-1] ? SW'(-s1_r) : SW'(s1_r);
    prod = XW'(ms) * XW'(MagC);
    rnd  = prod + XW'(64'd1 << (CoefFracBits - 1));
    pmag = (PW-1)'(rnd >> CoefFracBits);
    // Product magnitude is rounded half away from zero, then signed.
    p    = (s1_r[SW-1] ^ CoefNeg) ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    v    = (VW'(sample) <<< gbp_pkg::StateFrac) + VW'(p) - VW'(s2_r);
    if (v > VW'(StMax)) begin
      s0 = StMax;
    end else if (v < VW'(StMin)) begin
      s0 = StMin;
    end else begin
      s0 = SW'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (shift) begin
      s1_r <= nb_s1;
      s2_r <= nb_s2;
    end else if (upd) begin
      s1_r <= s0;
      s2_r <= s1_r;
    end
  end

  assign s1 = s1_r;
  assign s2 = s2_r;

endmodule

@@ rtl/gbp_power.sv @@
// Five-stage pipeline that turns one bin's resonator states into its power.
// Depends on gbp_pkg; fed from the head of the cell chain.

module gbp_power #(
  parameter int CoefFracBits = gbp_pkg::CoefFracBits,
  parameter int CoefW        = gbp_pkg::CoefFracBits + 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [gbp_pkg::StateW-1:0] s1,
  input  logic signed [gbp_pkg::StateW-1:0] s2,
  input  logic signed [CoefW-1:0]           coef,
  output logic                              pwr_vld,
  output logic [63:0]                       pwr
);

  localparam int IW = gbp_pkg::IntW;
  localparam int MW = CoefW - 1;
  localparam int HW = IW + MW;
  localparam int CW = 2 * IW + MW;
  localparam int QW = 2 * IW + 1;
  localparam int TW = 2 * IW + 4 + CoefFracBits;

  logic [4:0] vld_r;

  logic signed [IW-1:0] a, b;
  logic [IW-1:0]        ma_r, mb_r;
  logic [MW-1:0]        mc_r, mc2_r;
  logic                 pos_r, pos2_r, pos3_r, pos4_r;
  logic [2*IW-1:0]      aa_r, bb_r, ab_r;
  logic [QW-1:0]        sq_r, sq4_r;
  logic [HW-1:0]        hi_r, lo_r;
  logic [CW-1:0]        cr_r;
  logic signed [TW-1:0] t;
  logic [TW-1:0]        u;
  logic [63:0]          pwr_r;

  assign a = IW'(s1 >>> gbp_pkg::StateFrac);
  assign b = IW'(s2 >>> gbp_pkg::StateFrac);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= a[IW-1] ? IW'(-a) : IW'(a);
    mb_r   <= b[IW-1] ? IW'(-b) : IW'(b);
    mc_r   <= coef[CoefW-1] ? MW'(-coef) : MW'(coef);
    // The cross term is subtracted when c*a*b is nonnegative in sign.
    pos_r  <= ((a[IW-1] != b[IW-1]) == coef[CoefW-1]);

    aa_r   <= (2*IW)'(ma_r) * (2*IW)'(ma_r);
    bb_r   <= (2*IW)'(mb_r) * (2*IW)'(mb_r);
    ab_r   <= (2*IW)'(ma_r) * (2*IW)'(mb_r);
    mc2_r  <= mc_r;
    pos2_r <= pos_r;

    sq_r   <= QW'(aa_r) + QW'(bb_r);
    hi_r   <= HW'(ab_r[2*IW-1:IW]) * HW'(mc2_r);
    lo_r   <= HW'(ab_r[IW-1:0]) * HW'(mc2_r);
    pos3_r <= pos2_r;

    cr_r   <= (CW'(hi_r) << IW) + CW'(lo_r);
    sq4_r  <= sq_r;
    pos4_r <= pos3_r;

    pwr_r  <= (|u[TW-1:64]) ? {64{1'b1}} : u[63:0];
  end

  always_comb begin
    if (pos4_r) begin
      t = (TW'(sq4_r) << CoefFracBits) - TW'(cr_r);
    end else begin
      t = (TW'(sq4_r) << CoefFracBits) + TW'(cr_r);
    end
    // A negative or oversized result lands in the high bits and saturates.
    u = TW'(t) >> CoefFracBits;
  end

  assign pwr_vld = vld_r[4];
  assign pwr     = pwr_r;

endmodule

@@ rtl/gbp_bar_div.sv @@
// Bit-serial divider for the bar length floor(cols*power/max), one quotient bit a cycle.
// Depends on nothing but its ports; used by goertzel_bin_power_bank.

module gbp_bar_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] power,
  input  logic [7:0]  cols,
  input  logic [63:0] max,
  output logic        done,
  output logic [7:0]  quo
);

  logic [71:0] rem_r;
  logic [63:0] d_r;
  logic [2:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [7:0]  q_r;
  logic [71:0] trial;

  assign trial = 72'(d_r) << step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 3'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= 72'(power) * 72'(cols);
      d_r    <= max;
      step_r <= 3'd7;
      q_r    <= '0;
    end else if (busy_r) begin
      // Power never exceeds max, so the quotient fits in eight bits.
      if (rem_r >= trial) begin
        rem_r       <= rem_r - trial;
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 3'd1;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ tb/tb_goertzel_bin_power_bank.sv @@
// Self-checking testbench for goertzel_bin_power_bank: random frames of samples,
// an internal bit-exact predictor of the resonator bank and per-bin result checks.
// Depends on gbp_pkg and the RTL of the block.

class bin_power_tracker;
  localparam int Bins = gbp_pkg::NumBins;
  localparam int Frac = gbp_pkg::CoefFracBits;
  localparam longint StateHi = 64'sd140737488355327;
  localparam longint StateLo = -64'sd140737488355328;
  localparam longint unsigned PiFix     = 64'd3373259426;
  localparam longint unsigned TwoPiFix  = 64'd6746518852;
  localparam longint unsigned HalfPiFix = 64'd1686629713;

  logic signed [47:0] s_prev [Bins];
  logic signed [47:0] s_prev2 [Bins];
  longint             coef_k [Bins];
  logic [7:0]         bar_cols;
  gbp_pkg::out_t      expected_bins [$];
  int                 mismatches;

  function new();
    for (int k = 0; k < Bins; k++) begin
      s_prev[k]  = '0;
      s_prev2[k] = '0;
      coef_k[k]  = two_cos(k);
    end
    bar_cols   = 8'd40;
    mismatches = 0;
  endfunction

  // 2*cos(2*pi*k/Bins) with Frac fraction bits, from a Q30 series.
  function longint two_cos(int k);
    longint unsigned a, x, y2, term, m;
    longint sum;
    bit neg;
    int sh;
    a = k;
    neg = 1'b0;
    if (2 * a > Bins) a = Bins - a;
    x = (TwoPiFix * a) / Bins;
    if (x > HalfPiFix) begin
      x = PiFix - x;
      neg = 1'b1;
    end
    y2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int i = 1; i <= 10; i++) begin
      term = ((term * y2) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (neg) sum = -sum;
    sh = 29 - Frac;
    m = (sum < 0) ? -sum : sum;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (sum < 0) ? -longint'(m) : longint'(m);
  endfunction

  function logic signed [47:0] resonate(longint smp, longint c,
                                        logic signed [47:0] s1, logic signed [47:0] s2);
    longint a1, v, ps;
    longint unsigned ms, mc, p;
    a1 = s1;
    ms = (a1 < 0) ? -a1 : a1;
    mc = (c < 0) ? -c : c;
    p = (ms * mc + (64'd1 << (Frac - 1))) >> Frac;
    ps = ((a1 < 0) != (c < 0)) ? -longint'(p) : longint'(p);
    v = smp * 16384 + ps - longint'(s2);
    if (v > StateHi) v = StateHi;
    if (v < StateLo) v = StateLo;
    return v[47:0];
  endfunction

  function logic [63:0] power_of(logic signed [47:0] s1, logic signed [47:0] s2, longint c);
    logic signed [191:0] a, b, cw, num;
    a = s1 >>> 14;
    b = s2 >>> 14;
    cw = c;
    num = ((a * a + b * b) <<< Frac) - cw * a * b;
    num = num >>> Frac;
    if (num[191:64] != '0) return '1;
    return num[63:0];
  endfunction

  function int pending();
    return expected_bins.size();
  endfunction

  function void set_bar_cols(logic [7:0] v);
    bar_cols = v;
  endfunction

  function void take_sample(gbp_pkg::in_t d);
    logic signed [47:0] s0;
    logic [63:0] pw [Bins];
    logic [63:0] peak;
    logic [79:0] scaled;
    gbp_pkg::out_t r;
    for (int k = 0; k < Bins; k++) begin
      s0 = resonate(longint'(d.sample), coef_k[k], s_prev[k], s_prev2[k]);
      s_prev2[k] = s_prev[k];
      s_prev[k]  = s0;
    end
    if (!d.last_sample) return;
    peak = 64'd1;
    for (int k = 0; k < Bins; k++) begin
      pw[k] = power_of(s_prev[k], s_prev2[k], coef_k[k]);
      if (pw[k] > peak) peak = pw[k];
    end
    for (int k = 0; k < Bins; k++) begin
      scaled = pw[k] * bar_cols;
      scaled = scaled / peak;
      r.bin_index  = k[5:0];
      r.bin_power  = pw[k];
      r.bar_length = scaled[7:0];
      r.last_bin   = (k == Bins - 1);
      expected_bins.push_back(r);
      s_prev[k]  = '0;
      s_prev2[k] = '0;
    end
  endfunction

  function void check_bin(gbp_pkg::out_t got);
    gbp_pkg::out_t want;
    if (expected_bins.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected bin result: %p", got);
      return;
    end
    want = expected_bins.pop_front();
    if (got.bin_index !== want.bin_index || got.bin_power !== want.bin_power ||
        got.bar_length !== want.bar_length || got.last_bin !== want.last_bin) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Bin mismatch: expected idx=%0d pow=%0d bar=%0d last=%0d, ",
                  "got idx=%0d pow=%0d bar=%0d last=%0d"},
                 want.bin_index, want.bin_power, want.bar_length, want.last_bin,
                 got.bin_index, got.bin_power, got.bar_length, got.last_bin);
    end
  endfunction
endclass

module tb_goertzel_bin_power_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 1500;
  localparam int RandomItems = 250;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  gbp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  gbp_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [7:0]    cfg_wdata = '0;

  bin_power_tracker tracker = new();
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  hold_req = 0;
  bit  rx_busy = 0;
  int  gap_mode = 0;
  int  items_sent = 0;

  goertzel_bin_power_bank DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    logic nxt;
    int r;
    if (rst_n && out_valid && !out_stall) tracker.check_bin(out_data);
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (!rx_busy) begin
      nxt = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      nxt = (r >= 65);
      if (r >= 95) stall_left = $urandom_range(5, 40);
      else if (r >= 65) stall_left = $urandom_range(0, 2);
    end
    out_stall <= nxt;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_sample(gbp_pkg::in_t d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_sample(d);
    items_sent++;
  endtask

  // Patterns: 0 random, 1 full positive, 2 full negative, 3 alternating extremes,
  // 4 small values, 5 silence.
  task automatic run_frame(int len, int pattern);
    gbp_pkg::in_t d;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        1: d.sample = 8'sd127;
        2: d.sample = -8'sd128;
        3: d.sample = (i % 2 == 0) ? 8'sd127 : -8'sd128;
        4: d.sample = 8'($urandom_range(0, 6)) - 8'sd3;
        5: d.sample = 8'sd0;
        default: d.sample = 8'($urandom);
      endcase
      d.last_sample = (i == len - 1);
      send_sample(d);
    end
  endtask

  task automatic write_bar_cols(logic [7:0] v);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_bar_cols(v);
  endtask

  initial begin
    int len;
    int frames;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset bar scale, then the extreme scales.
    run_frame(1, 1);
    run_frame(1, 2);
    run_frame(4, 3);
    run_frame(2, 5);
    write_bar_cols(8'd255);
    rx_busy = 1;
    gap_mode = 1;
    run_frame(6, 0);
    run_frame(5, 4);
    write_bar_cols(8'd0);
    run_frame(5, 0);
    write_bar_cols(8'd1);
    gap_mode = 0;
    rx_busy = 0;
    // Longer frames of full-scale input build up large states and powers.
    run_frame(100, 1);
    write_bar_cols(8'd200);
    run_frame(100, 3);

    items_sent = 0;
    frames = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: write_bar_cols(8'd0);
          1: write_bar_cols(8'd255);
          2: write_bar_cols(8'd1);
          default: write_bar_cols(8'($urandom_range(1, 255)));
        endcase
      end
      gap_mode = ($urandom_range(0, 3) != 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      if (frames == 4) hold_req = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      run_frame(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0);
      frames++;
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
